// File: rtl/core/lsf_pkg.sv
package lsf_pkg;

  // Point capacity of one set
  localparam int MAX_POINTS = 1024;
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

  // Input sample and accumulator widths
  localparam int X_W    = 24;
  localparam int PROD_W = 2 * X_W;
  localparam int SX_W   = 34;
  localparam int SXX_W  = 58;

  // Serial multiplier: A operand up to SXX_W bits, B operand up to SX_W bits
  localparam int MA_W = SXX_W;
  localparam int MB_W = SX_W;
  localparam int MP_W = MA_W + MB_W;

  // Signed width of den / slope numerator / intercept numerator
  localparam int CB_W = 96;

  // Divider
  localparam int RES_W   = 48;
  localparam int Q_W     = RES_W + 1;
  localparam int DV_W    = 120;
  localparam int K_SHIFT = 25;
  localparam int R_SHIFT = 13;
  localparam int STEP_W  = $clog2(Q_W);

  // Set queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Port packing
  localparam int IN_TDATA_W  = 2 * X_W;
  localparam int OUT_FIELD_W = 2 * RES_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_SATURATED  = 2'd2,
    STATUS_OVERFLOW   = 2'd3
  } status_e;

  // Totals of one finished set, two's complement where signed
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SX_W-1:0]    sum_x;
    logic [SX_W-1:0]    sum_y;
    logic [SXX_W-1:0]   sum_xx;
    logic [SXX_W-1:0]   sum_xy;
    logic               overflow;
  } sums_t;

  typedef struct packed {
    logic [RES_W-1:0]   slope;
    logic [RES_W-1:0]   intercept;
    status_e            status;
    logic [COUNT_W-1:0] points;
  } result_t;

endpackage

// File: rtl/core/least_squares_line_fit_unit.sv
// Least-squares line fit over a stream of (x, y) points in signed Q12.12.
// Points are taken one per cycle; the word with tlast closes the set and is
// itself part of it. For each set one result word gives slope and intercept
// in signed Q24.24, the point count and a status in tuser (0 ok, 1 degenerate:
// fewer than two points or zero x spread, 2 saturated, 3 more than 1024 points
// offered, the extra ones dropped). Accumulation runs in a three-stage
// pipeline; finished sets wait in a two-deep queue for the fit engine, which
// takes one set at a time: six products on a shared shift-add multiplier,
// then two restoring divisions. The input stalls only when a set closes while
// two finished sets are still queued.
module least_squares_line_fit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [lsf_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // x_value, y_value
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [lsf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // slope, intercept, points_used
  output logic [1:0]                          m_axis_tuser_o   // status
);

  logic             push;
  logic             full;
  lsf_pkg::sums_t   push_sums;
  logic             set_valid;
  logic             set_pop;
  lsf_pkg::sums_t   set_sums;
  lsf_pkg::result_t result;

  lsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .x_i        (s_axis_tdata_i[lsf_pkg::X_W-1:0]),
    .y_i        (s_axis_tdata_i[2*lsf_pkg::X_W-1:lsf_pkg::X_W]),
    .last_i     (s_axis_tlast_i),
    .push_o     (push),
    .full_i     (full),
    .sums_o     (push_sums)
  );

  lsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_sums),
    .full_o  (full),
    .valid_o (set_valid),
    .pop_i   (set_pop),
    .data_o  (set_sums)
  );

  lsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_valid_i (set_valid),
    .set_pop_o   (set_pop),
    .set_i       (set_sums),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {{(lsf_pkg::OUT_TDATA_W - lsf_pkg::OUT_FIELD_W){1'b0}},
                           result.points, result.intercept, result.slope};
  assign m_axis_tuser_o = result.status;

endmodule

// File: rtl/core/lsf_front.sv
module lsf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lsf_pkg::X_W-1:0]      x_i,
  input  logic [lsf_pkg::X_W-1:0]      y_i,
  input  logic                         last_i,
  output logic                         push_o,
  input  logic                         full_i,
  output lsf_pkg::sums_t               sums_o
);

  logic                              s1_valid_q;
  logic                              s1_last_q;
  logic signed [lsf_pkg::X_W-1:0]    s1_x_q;
  logic signed [lsf_pkg::X_W-1:0]    s1_y_q;

  logic                              s2_valid_q;
  logic                              s2_last_q;
  logic [lsf_pkg::X_W-1:0]           s2_x_q;
  logic [lsf_pkg::X_W-1:0]           s2_y_q;
  logic [lsf_pkg::PROD_W-1:0]        s2_xx_q;
  logic [lsf_pkg::PROD_W-1:0]        s2_xy_q;

  logic signed [lsf_pkg::PROD_W-1:0] xx_prod;
  logic signed [lsf_pkg::PROD_W-1:0] xy_prod;

  logic [lsf_pkg::COUNT_W-1:0]       cnt_q, cnt_d;
  logic [lsf_pkg::SX_W-1:0]          sx_q, sx_d;
  logic [lsf_pkg::SX_W-1:0]          sy_q, sy_d;
  logic [lsf_pkg::SXX_W-1:0]         sxx_q, sxx_d;
  logic [lsf_pkg::SXX_W-1:0]         sxy_q, sxy_d;
  logic                              ovf_q, ovf_d;

  logic                              advance;
  logic                              room;
  logic                              take;

  // whole pipeline holds while a closing point waits for queue space
  assign advance    = !(s2_valid_q && s2_last_q && full_i);
  assign in_ready_o = advance;

  assign xx_prod = s1_x_q * s1_x_q;
  assign xy_prod = s1_x_q * s1_y_q;

  assign room = cnt_q < lsf_pkg::COUNT_W'(lsf_pkg::MAX_POINTS);
  assign take = s2_valid_q && room;

  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    sxy_d = sxy_q;
    ovf_d = ovf_q | (s2_valid_q && !room);
    if (take) begin
      cnt_d = cnt_q + lsf_pkg::COUNT_W'(1);
      sx_d  = sx_q + {{(lsf_pkg::SX_W - lsf_pkg::X_W){s2_x_q[lsf_pkg::X_W-1]}}, s2_x_q};
      sy_d  = sy_q + {{(lsf_pkg::SX_W - lsf_pkg::X_W){s2_y_q[lsf_pkg::X_W-1]}}, s2_y_q};
      sxx_d = sxx_q + {{(lsf_pkg::SXX_W - lsf_pkg::PROD_W){1'b0}}, s2_xx_q};
      sxy_d = sxy_q + {{(lsf_pkg::SXX_W - lsf_pkg::PROD_W){s2_xy_q[lsf_pkg::PROD_W-1]}},
                       s2_xy_q};
    end
  end

  assign push_o          = s2_valid_q && s2_last_q && advance;
  assign sums_o.count    = cnt_d;
  assign sums_o.sum_x    = sx_d;
  assign sums_o.sum_y    = sy_d;
  assign sums_o.sum_xx   = sxx_d;
  assign sums_o.sum_xy   = sxy_d;
  assign sums_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q <= last_i;
      s1_x_q    <= x_i;
      s1_y_q    <= y_i;
      s2_last_q <= s1_last_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_xx_q   <= xx_prod;
      s2_xy_q   <= xy_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else if (advance) begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sxx_q <= sxx_d;
      sxy_q <= sxy_d;
      ovf_q <= ovf_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lsf_pkg::COUNT_W'(lsf_pkg::MAX_POINTS))
    else $error("point count above capacity");

endmodule

// File: rtl/core/lsf_queue.sv
module lsf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsf_pkg::sums_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output lsf_pkg::sums_t data_o
);

  lsf_pkg::sums_t           mem_q [lsf_pkg::QUEUE_DEPTH];
  logic [lsf_pkg::QP_W-1:0] wr_ptr_q;
  logic [lsf_pkg::QP_W-1:0] rd_ptr_q;
  logic [lsf_pkg::QC_W-1:0] cnt_q;
  logic                     do_pop;

  assign full_o  = cnt_q == lsf_pkg::QC_W'(lsf_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lsf_pkg::QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + lsf_pkg::QP_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + lsf_pkg::QC_W'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - lsf_pkg::QC_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("set pushed into full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lsf_pkg::QC_W'(lsf_pkg::QUEUE_DEPTH))
    else $error("queue fill above depth");

endmodule

// File: rtl/core/lsf_back.sv
module lsf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             set_valid_i,
  output logic             set_pop_o,
  input  lsf_pkg::sums_t   set_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsf_pkg::result_t result_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // product order: den = n*Sxx - Sx*Sx, knum = n*Sxy - Sx*Sy, rnum = Sy*Sxx - Sx*Sxy
  localparam logic [2:0] PR_N_SXX  = 3'd0;
  localparam logic [2:0] PR_SX_SX  = 3'd1;
  localparam logic [2:0] PR_N_SXY  = 3'd2;
  localparam logic [2:0] PR_SX_SY  = 3'd3;
  localparam logic [2:0] PR_SY_SXX = 3'd4;
  localparam logic [2:0] PR_SX_SXY = 3'd5;

  localparam logic [1:0] TG_DEN  = 2'd0;
  localparam logic [1:0] TG_KNUM = 2'd1;
  localparam logic [1:0] TG_RNUM = 2'd2;

  localparam logic [lsf_pkg::Q_W-1:0] LIM_POS =
    {{(lsf_pkg::Q_W - lsf_pkg::RES_W + 1){1'b0}}, {(lsf_pkg::RES_W - 1){1'b1}}};
  localparam logic [lsf_pkg::Q_W-1:0] LIM_NEG = LIM_POS + lsf_pkg::Q_W'(1);

  logic [2:0]                  state_q;
  lsf_pkg::sums_t              snap_q;
  logic [2:0]                  prod_idx_q;
  logic [lsf_pkg::STEP_W-1:0]  step_q;
  logic [lsf_pkg::MB_W-1:0]    mul_b_q;
  logic [lsf_pkg::MP_W-1:0]    mul_acc_q;
  logic [lsf_pkg::CB_W-1:0]    den_q;
  logic [lsf_pkg::CB_W-1:0]    knum_q;
  logic [lsf_pkg::CB_W-1:0]    rnum_q;
  logic [lsf_pkg::DV_W-1:0]    rem_q;
  logic [lsf_pkg::DV_W-1:0]    dsh_q;
  logic [lsf_pkg::Q_W-1:0]     quo_q;
  logic                        div_neg_q;
  logic                        div_icpt_q;
  logic                        sat_q;
  logic [lsf_pkg::RES_W-1:0]   slope_q;
  logic [lsf_pkg::RES_W-1:0]   icpt_q;
  lsf_pkg::status_e            status_q;
  logic                        out_valid_q;
  lsf_pkg::result_t            out_q;

  // operand magnitudes
  logic                        sx_neg, sy_neg, sxy_neg;
  logic [lsf_pkg::SX_W-1:0]    sx_mag, sy_mag;
  logic [lsf_pkg::SXX_W-1:0]   sxy_mag;
  logic [lsf_pkg::MB_W-1:0]    n_ext;

  logic [lsf_pkg::MA_W-1:0]    op_a;
  logic [lsf_pkg::MB_W-1:0]    op_b;
  logic                        op_neg;
  logic [1:0]                  op_tgt;

  logic [lsf_pkg::MP_W-1:0]    mul_sum;
  logic [lsf_pkg::CB_W-1:0]    prod_ext;
  logic [lsf_pkg::CB_W-1:0]    addend;
  logic                        mul_last;

  logic [lsf_pkg::DV_W-1:0]    den_ext;
  logic                        knum_neg, rnum_neg;
  logic [lsf_pkg::CB_W-1:0]    knum_mag, rnum_mag;
  logic [lsf_pkg::DV_W-1:0]    knum_rem, rnum_rem;
  logic                        degenerate;

  logic                        ge;
  logic [lsf_pkg::DV_W-1:0]    rem_n;
  logic [lsf_pkg::Q_W-1:0]     quo_n;
  logic [lsf_pkg::Q_W-1:0]     lim;
  logic                        q_over;
  logic [lsf_pkg::Q_W-1:0]     q_clamp;
  logic [lsf_pkg::RES_W-1:0]   q_val;
  logic                        div_last;
  logic                        out_free;

  assign sx_neg  = snap_q.sum_x[lsf_pkg::SX_W-1];
  assign sy_neg  = snap_q.sum_y[lsf_pkg::SX_W-1];
  assign sxy_neg = snap_q.sum_xy[lsf_pkg::SXX_W-1];
  assign sx_mag  = sx_neg ? (~snap_q.sum_x + lsf_pkg::SX_W'(1)) : snap_q.sum_x;
  assign sy_mag  = sy_neg ? (~snap_q.sum_y + lsf_pkg::SX_W'(1)) : snap_q.sum_y;
  assign sxy_mag = sxy_neg ? (~snap_q.sum_xy + lsf_pkg::SXX_W'(1)) : snap_q.sum_xy;
  assign n_ext   = {{(lsf_pkg::MB_W - lsf_pkg::COUNT_W){1'b0}}, snap_q.count};

  // op_neg already folds in whether the product is subtracted
  always_comb begin
    op_a   = snap_q.sum_xx;
    op_b   = n_ext;
    op_neg = 1'b0;
    op_tgt = TG_DEN;
    case (prod_idx_q)
      PR_N_SXX: begin
        op_a   = snap_q.sum_xx;
        op_b   = n_ext;
        op_neg = 1'b0;
        op_tgt = TG_DEN;
      end
      PR_SX_SX: begin
        op_a   = {{(lsf_pkg::MA_W - lsf_pkg::SX_W){1'b0}}, sx_mag};
        op_b   = sx_mag;
        op_neg = 1'b1;
        op_tgt = TG_DEN;
      end
      PR_N_SXY: begin
        op_a   = sxy_mag;
        op_b   = n_ext;
        op_neg = sxy_neg;
        op_tgt = TG_KNUM;
      end
      PR_SX_SY: begin
        op_a   = {{(lsf_pkg::MA_W - lsf_pkg::SX_W){1'b0}}, sx_mag};
        op_b   = sy_mag;
        op_neg = !(sx_neg ^ sy_neg);
        op_tgt = TG_KNUM;
      end
      PR_SY_SXX: begin
        op_a   = snap_q.sum_xx;
        op_b   = sy_mag;
        op_neg = sy_neg;
        op_tgt = TG_RNUM;
      end
      PR_SX_SXY: begin
        op_a   = sxy_mag;
        op_b   = sx_mag;
        op_neg = !(sxy_neg ^ sx_neg);
        op_tgt = TG_RNUM;
      end
      default: begin
        op_a   = snap_q.sum_xx;
        op_b   = n_ext;
        op_neg = 1'b0;
        op_tgt = TG_DEN;
      end
    endcase
  end

  // MSB-first shift-add, one multiplier bit per cycle
  assign mul_sum  = {mul_acc_q[lsf_pkg::MP_W-2:0], 1'b0}
                  + (mul_b_q[lsf_pkg::MB_W-1]
                     ? {{(lsf_pkg::MP_W - lsf_pkg::MA_W){1'b0}}, op_a}
                     : {lsf_pkg::MP_W{1'b0}});
  assign prod_ext = {{(lsf_pkg::CB_W - lsf_pkg::MP_W){1'b0}}, mul_sum};
  assign addend   = op_neg ? (~prod_ext + lsf_pkg::CB_W'(1)) : prod_ext;
  assign mul_last = step_q == lsf_pkg::STEP_W'(lsf_pkg::MB_W - 1);

  // rounded quotient: q = (2|num| + den) / (2 den), so the divider sees
  // remainder |num|*2 + den and divisor 2 den, aligned at quotient bit Q_W-1
  assign den_ext    = {{(lsf_pkg::DV_W - lsf_pkg::CB_W){1'b0}}, den_q};
  assign knum_neg   = knum_q[lsf_pkg::CB_W-1];
  assign rnum_neg   = rnum_q[lsf_pkg::CB_W-1];
  assign knum_mag   = knum_neg ? (~knum_q + lsf_pkg::CB_W'(1)) : knum_q;
  assign rnum_mag   = rnum_neg ? (~rnum_q + lsf_pkg::CB_W'(1)) : rnum_q;
  assign knum_rem   = ({{(lsf_pkg::DV_W - lsf_pkg::CB_W){1'b0}}, knum_mag} << lsf_pkg::K_SHIFT)
                    + den_ext;
  assign rnum_rem   = ({{(lsf_pkg::DV_W - lsf_pkg::CB_W){1'b0}}, rnum_mag} << lsf_pkg::R_SHIFT)
                    + den_ext;
  assign degenerate = (snap_q.count < lsf_pkg::COUNT_W'(2)) || (den_q == '0)
                    || den_q[lsf_pkg::CB_W-1];

  assign ge       = rem_q >= dsh_q;
  assign rem_n    = ge ? (rem_q - dsh_q) : rem_q;
  assign quo_n    = {quo_q[lsf_pkg::Q_W-2:0], ge};
  assign lim      = div_neg_q ? LIM_NEG : LIM_POS;
  assign q_over   = quo_n > lim;
  assign q_clamp  = q_over ? lim : quo_n;
  assign q_val    = div_neg_q ? (~q_clamp[lsf_pkg::RES_W-1:0] + lsf_pkg::RES_W'(1))
                              : q_clamp[lsf_pkg::RES_W-1:0];
  assign div_last = step_q == lsf_pkg::STEP_W'(lsf_pkg::Q_W - 1);

  assign out_free  = !out_valid_q || out_ready_i;
  assign set_pop_o = (state_q == ST_IDLE) && set_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (set_valid_i) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_last) begin
            state_q <= (prod_idx_q == PR_SX_SXY) ? ST_CHECK : ST_LOAD;
          end
        end
        ST_CHECK: begin
          state_q <= degenerate ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (div_last && div_icpt_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        snap_q     <= set_i;
        prod_idx_q <= PR_N_SXX;
        den_q      <= '0;
        knum_q     <= '0;
        rnum_q     <= '0;
        sat_q      <= 1'b0;
      end
      ST_LOAD: begin
        mul_b_q   <= op_b;
        mul_acc_q <= '0;
        step_q    <= '0;
      end
      ST_MUL: begin
        mul_acc_q <= mul_sum;
        mul_b_q   <= {mul_b_q[lsf_pkg::MB_W-2:0], 1'b0};
        step_q    <= step_q + lsf_pkg::STEP_W'(1);
        if (mul_last) begin
          prod_idx_q <= prod_idx_q + 3'd1;
          case (op_tgt)
            TG_DEN:  den_q  <= den_q + addend;
            TG_KNUM: knum_q <= knum_q + addend;
            TG_RNUM: rnum_q <= rnum_q + addend;
            default: den_q  <= den_q;
          endcase
        end
      end
      ST_CHECK: begin
        slope_q    <= '0;
        icpt_q     <= '0;
        status_q   <= lsf_pkg::STATUS_DEGENERATE;
        rem_q      <= knum_rem;
        dsh_q      <= den_ext << lsf_pkg::Q_W;
        quo_q      <= '0;
        div_neg_q  <= knum_neg;
        div_icpt_q <= 1'b0;
        step_q     <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_n;
        dsh_q  <= dsh_q >> 1;
        quo_q  <= quo_n;
        step_q <= step_q + lsf_pkg::STEP_W'(1);
        if (div_last) begin
          sat_q <= sat_q | q_over;
          if (!div_icpt_q) begin
            slope_q    <= q_val;
            rem_q      <= rnum_rem;
            dsh_q      <= den_ext << lsf_pkg::Q_W;
            quo_q      <= '0;
            div_neg_q  <= rnum_neg;
            div_icpt_q <= 1'b1;
            step_q     <= '0;
          end else begin
            icpt_q <= q_val;
            if (snap_q.overflow) begin
              status_q <= lsf_pkg::STATUS_OVERFLOW;
            end else if (sat_q || q_over) begin
              status_q <= lsf_pkg::STATUS_SATURATED;
            end else begin
              status_q <= lsf_pkg::STATUS_OK;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.slope     <= slope_q;
          out_q.intercept <= icpt_q;
          out_q.status    <= status_q;
          out_q.points    <= snap_q.count;
        end
      end
      default: begin
        step_q <= '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == lsf_pkg::STATUS_DEGENERATE)
      |-> (out_q.slope == '0 && out_q.intercept == '0))
    else $error("degenerate fit with nonzero result");

  a_fit_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != lsf_pkg::STATUS_DEGENERATE)
      |-> (out_q.points >= lsf_pkg::COUNT_W'(2)))
    else $error("fit reported over fewer than two points");

endmodule

// File: test/least_squares_line_fit_unit_test.sv
`timescale 1ns / 100ps

module least_squares_line_fit_unit_test;

  typedef struct packed {
    logic [lsf_pkg::X_W-1:0] x;
    logic [lsf_pkg::X_W-1:0] y;
    logic                    last;
    logic [3:0]              gap;    // idle cycles before this word is offered
    logic                    drain;  // hold this word until every fit is back
  } point_word_t;

  typedef enum int {
    ON_LINE,
    SPREAD_RANDOM,
    NARROW_X,
    EXTREMES,
    SAME_X
  } point_style_e;

  localparam logic [lsf_pkg::X_W-1:0] V_MIN = 24'h800000;
  localparam logic [lsf_pkg::X_W-1:0] V_MAX = 24'h7FFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [lsf_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [lsf_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]                      m_tuser;

  least_squares_line_fit_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Stimulus and expected fits
  point_word_t      point_words[$];
  lsf_pkg::result_t fits_due[$];
  int               words_queued = 0;
  int               words_in = 0;
  int               fault_count = 0;
  bit               tx_burst = 1'b0;
  logic             hold_output = 1'b0;

  // Running sums of the set being collected
  int unsigned acc_n = 0;
  longint      acc_sx = 0;
  longint      acc_sy = 0;
  longint      acc_sxx = 0;
  longint      acc_sxy = 0;
  bit          acc_over = 1'b0;

  // round(num / den), halves away from zero, clamped to 48-bit signed
  function automatic logic [lsf_pkg::RES_W-1:0] rounded_quotient(
      input logic signed [127:0] num,
      input logic [127:0] den,
      output bit clamped);
    logic [127:0]              mag;
    logic [127:0]              q;
    logic [127:0]              lim;
    logic [lsf_pkg::RES_W-1:0] v;
    mag = num[127] ? -num : num;
    q = ((mag << 1) + den) / (den << 1);
    lim = num[127] ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    clamped = q > lim;
    if (clamped) begin
      q = lim;
    end
    v = q[lsf_pkg::RES_W-1:0];
    return num[127] ? -v : v;
  endfunction

  task automatic accumulate_point(input point_word_t w);
    longint              xv;
    longint              yv;
    logic signed [127:0] n_w;
    logic signed [127:0] sx_w;
    logic signed [127:0] sy_w;
    logic signed [127:0] sxx_w;
    logic signed [127:0] sxy_w;
    logic signed [127:0] den;
    logic signed [127:0] knum;
    logic signed [127:0] rnum;
    bit                  sat_k;
    bit                  sat_r;
    lsf_pkg::result_t    fit;
    xv = $signed(w.x);
    yv = $signed(w.y);
    if (acc_n >= lsf_pkg::MAX_POINTS) begin
      acc_over = 1'b1;
    end else begin
      acc_n++;
      acc_sx += xv;
      acc_sy += yv;
      acc_sxx += xv * xv;
      acc_sxy += xv * yv;
    end
    if (w.last) begin
      n_w = acc_n;
      sx_w = acc_sx;
      sy_w = acc_sy;
      sxx_w = acc_sxx;
      sxy_w = acc_sxy;
      den = n_w * sxx_w - sx_w * sx_w;
      fit = '0;
      fit.points = acc_n[lsf_pkg::COUNT_W-1:0];
      if (acc_n < 2 || den <= 0) begin
        fit.status = lsf_pkg::STATUS_DEGENERATE;
      end else begin
        knum = n_w * sxy_w - sx_w * sy_w;
        rnum = sy_w * sxx_w - sx_w * sxy_w;
        fit.slope = rounded_quotient(knum <<< 24, den, sat_k);
        fit.intercept = rounded_quotient(rnum <<< 12, den, sat_r);
        if (acc_over) begin
          fit.status = lsf_pkg::STATUS_OVERFLOW;
        end else if (sat_k || sat_r) begin
          fit.status = lsf_pkg::STATUS_SATURATED;
        end else begin
          fit.status = lsf_pkg::STATUS_OK;
        end
      end
      fits_due.push_back(fit);
      acc_n = 0;
      acc_sx = 0;
      acc_sy = 0;
      acc_sxx = 0;
      acc_sxy = 0;
      acc_over = 1'b0;
    end
  endtask

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic logic [lsf_pkg::X_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return V_MIN;
      1: return V_MAX;
      2: return '0;
      3: return '1;
      4: return 24'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_point(input logic [lsf_pkg::X_W-1:0] x,
                             input logic [lsf_pkg::X_W-1:0] y,
                             input logic last, input bit drain);
    point_word_t w;
    w.x = x;
    w.y = y;
    w.last = last;
    w.gap = tx_burst ? 4'd0 : 4'($urandom_range(0, 15));
    w.drain = drain;
    point_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_set(input int count, input point_style_e style, input bit drain);
    int x0;
    int step;
    int slope_i;
    int base;
    int xi;
    int yi;
    x0 = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
    step = int'($urandom_range(1, 4096));
    slope_i = int'($urandom_range(0, 64)) - 32;
    base = int'($urandom_range(0, 2 ** 22)) - 2 ** 21;
    for (int i = 0; i < count; i++) begin
      case (style)
        ON_LINE: begin
          xi = x0 + i * step + int'($urandom_range(0, 63)) - 32;
          yi = base + ((slope_i * (xi - x0)) >>> 2) + int'($urandom_range(0, 511)) - 256;
        end
        SPREAD_RANDOM: begin
          xi = $urandom;
          yi = $urandom;
        end
        NARROW_X: begin
          // x spread of a few LSBs: slope and intercept tend to clamp
          xi = x0 + int'($urandom_range(0, 3));
          yi = $urandom;
        end
        EXTREMES: begin
          xi = pick_extreme();
          yi = pick_extreme();
        end
        default: begin
          xi = x0;
          yi = $urandom;
        end
      endcase
      queue_point(xi[lsf_pkg::X_W-1:0], yi[lsf_pkg::X_W-1:0], i == count - 1,
                  drain && i == 0);
    end
  endtask

  // Driver: offers queued points, feeds the predictor on each accepted word
  point_word_t on_wire;
  int          gap_count = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_point(on_wire);
        words_in <= words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (point_words.size() != 0 && gap_count >= point_words[0].gap &&
            !(point_words[0].drain && fits_due.size() != 0)) begin
          on_wire = point_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_wire.y, on_wire.x};
          s_tlast <= on_wire.last;
          gap_count <= 0;
        end else begin
          s_tvalid <= 1'b0;
          gap_count <= gap_count + 1;
        end
      end
    end
  end

  // Monitor: checks each fit against the oldest expectation
  lsf_pkg::result_t got;
  lsf_pkg::result_t exp_fit;
  int               fits_out = 0;
  int               rx_wait = 0;
  int               wait_next;
  logic             ready_next;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      wait_next = rx_wait;
      if (m_tvalid && m_tready) begin
        got.slope = m_tdata[lsf_pkg::RES_W-1:0];
        got.intercept = m_tdata[2*lsf_pkg::RES_W-1:lsf_pkg::RES_W];
        got.points = m_tdata[2*lsf_pkg::RES_W +: lsf_pkg::COUNT_W];
        got.status = lsf_pkg::status_e'(m_tuser);
        if (fits_due.size() == 0) begin
          log_fault($sformatf("unexpected fit: slope %h intercept %h status %0d points %0d",
                              got.slope, got.intercept, got.status, got.points));
        end else begin
          exp_fit = fits_due.pop_front();
          if (got.slope !== exp_fit.slope || got.intercept !== exp_fit.intercept ||
              got.status !== exp_fit.status || got.points !== exp_fit.points) begin
            log_fault($sformatf({"fit %0d mismatch (exp/got): slope %h/%h ",
                                 "intercept %h/%h status %0d/%0d points %0d/%0d"},
                                fits_out, exp_fit.slope, got.slope, exp_fit.intercept,
                                got.intercept, exp_fit.status, got.status,
                                exp_fit.points, got.points));
          end
        end
        fits_out++;
        wait_next = (fits_out % 50 < 12) ? 0 : $urandom_range(0, 15);
      end
      if (hold_output) begin
        ready_next = 1'b0;
      end else if (wait_next > 0) begin
        ready_next = 1'b0;
        wait_next--;
      end else begin
        ready_next = 1'b1;
      end
      rx_wait <= wait_next;
      m_tready <= ready_next;
    end
  end

  // Long output stall while points keep coming, so the set queue backs up
  initial begin
    while (words_in < 100) @(posedge clk_i);
    hold_output <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int random_start;
    int r;
    point_style_e style;

    // single point, then two points on one x: both degenerate
    queue_point(24'd0, 24'd0, 1'b1, 1'b0);
    queue_point(V_MAX, V_MAX, 1'b0, 1'b0);
    queue_point(V_MAX, V_MIN, 1'b1, 1'b0);
    // full-scale diagonal
    queue_point(V_MIN, V_MAX, 1'b0, 1'b0);
    queue_point(V_MAX, V_MIN, 1'b1, 1'b0);
    // one LSB of x spread, full y swing: slope clamps
    queue_point(24'd0, V_MIN, 1'b0, 1'b0);
    queue_point(24'd1, V_MAX, 1'b1, 1'b0);
    // far from the origin: both clamp
    queue_point(V_MAX - 24'd1, V_MIN, 1'b0, 1'b0);
    queue_point(V_MAX, V_MAX, 1'b1, 1'b0);
    // exact line y = 2x + 1.0
    queue_point(-24'sd3, 24'h000FFA, 1'b0, 1'b0);
    queue_point(-24'sd1, 24'h000FFE, 1'b0, 1'b0);
    queue_point(24'd2, 24'h001004, 1'b0, 1'b0);
    queue_point(24'd5, 24'h00100A, 1'b1, 1'b0);
    queue_point('1, V_MAX, 1'b0, 1'b0);
    queue_point(24'd0, 24'd0, 1'b0, 1'b0);
    queue_point(24'd1, V_MIN, 1'b1, 1'b0);

    random_start = words_queued;
    while (words_queued - random_start < 250) begin
      r = $urandom_range(0, 19);
      if (r < 8) begin
        style = ON_LINE;
      end else if (r < 12) begin
        style = SPREAD_RANDOM;
      end else if (r < 15) begin
        style = NARROW_X;
      end else if (r < 18) begin
        style = EXTREMES;
      end else begin
        style = SAME_X;
      end
      tx_burst = ($urandom_range(0, 5) == 0);
      queue_set(($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8),
                style, words_queued == random_start || $urandom_range(0, 29) == 0);
    end

    // capacity: full set plus dropped words, then a short set after it
    tx_burst = 1'b0;
    queue_set(lsf_pkg::MAX_POINTS + 3, ON_LINE, 1'b1);
    queue_set(3, ON_LINE, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (point_words.size() != 0 || s_tvalid) @(posedge clk_i);
    while (fits_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
